FILE: sv/kvs_pkg.sv
// ============================================================================
// kvs_pkg: shared types and constants for the keyframe vector sampler
// Payload structs, command codes, controller states and datapath commands.
// ============================================================================
package kvs_pkg;

   localparam int MAX_KEYS   = 64;
   localparam int IDX_W      = $clog2(MAX_KEYS);
   localparam int CNT_W      = $clog2(MAX_KEYS + 1);
   localparam int FRAC_W     = 17;
   localparam int QUO_STEPS  = 48;   // quotient bits of (dt << 16) / span
   localparam int STEP_W     = $clog2(QUO_STEPS + 1);
   localparam logic [31:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_SAMPLE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]         cmd;
      logic [31:0]        item_time;
      logic signed [31:0] in_x;
      logic signed [31:0] in_y;
      logic signed [31:0] in_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST_RD,
      ST_FIRST_CHK,
      ST_SEG_RD,
      ST_SEG_CHK,
      ST_DIV,
      ST_MUL,
      ST_SUM,
      ST_LAST_RD,
      ST_LAST_CHK,
      ST_OUT
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic             load_req;     // capture the accepted request
      logic             clear;
      logic             append;
      logic             rd_en;        // read entry rd_idx (and rd_idx+1 lines)
      logic [IDX_W-1:0] rd_idx;
      logic             seg_load;     // latch the current segment pair
      logic             div_start;
      logic             div_step;
      logic             mul;
      logic             sum;
      logic             res_one;      // result is (1,1,1)
      logic             res_key;      // result is the key just read (v0)
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic [CNT_W-1:0] key_count;
      logic [1:0]       cmd;
      logic             le_first;     // time <= t0 of entry read
      logic             brackets;     // t0 <= time <= t1
      logic             span_zero;
   } sts_type;

endpackage

FILE: sv/kvs_ctrl.sv
// ============================================================================
// kvs_ctrl: sequencing controller
// Walks the key table one segment at a time and steps the divider.
// ============================================================================
module kvs_ctrl
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic             pend_ff, pend_in;   // request captured, not yet decoded

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
         step_ff  <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         step_ff  <= step_in;
         pend_ff  <= pend_in;
      end
   end

   logic accept;
   assign req_ready = (state_ff == ST_IDLE) && !pend_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = (state_ff == ST_OUT);

   // Next state.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      step_in  = step_ff;
      pend_in  = pend_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pend_ff) begin
               pend_in = 1'b0;
               idx_in  = '0;
               if (sts.cmd == CMD_SAMPLE) begin
                  if (sts.key_count == '0) state_in = ST_OUT;
                  else                     state_in = ST_FIRST_RD;
               end
            end else if (accept && req_valid) begin
               pend_in = 1'b1;
            end
         end
         ST_FIRST_RD:  state_in = ST_FIRST_CHK;
         ST_FIRST_CHK: begin
            if (sts.key_count == CNT_W'(1) || sts.le_first) state_in = ST_OUT;
            else                                             state_in = ST_SEG_RD;
         end
         ST_SEG_RD:  state_in = ST_SEG_CHK;
         ST_SEG_CHK: begin
            if (sts.brackets) begin
               if (sts.span_zero) state_in = ST_OUT;
               else begin
                  state_in = ST_DIV;
                  step_in  = '0;
               end
            end else if ({1'b0, idx_ff} + CNT_W'(2) >= sts.key_count) begin
               state_in = ST_LAST_RD;
            end else begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = ST_SEG_RD;
            end
         end
         ST_DIV: begin
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(QUO_STEPS - 1)) state_in = ST_MUL;
         end
         ST_MUL:      state_in = ST_SUM;
         ST_SUM:      state_in = ST_OUT;
         ST_LAST_RD:  state_in = ST_LAST_CHK;
         ST_LAST_CHK: state_in = ST_OUT;
         ST_OUT:      if (rsp_ready) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      ctl = '0;
      ctl.rd_idx = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctl.load_req = accept;
            if (pend_ff) begin
               ctl.clear  = (sts.cmd == CMD_CLEAR);
               ctl.append = (sts.cmd == CMD_APPEND);
               ctl.res_one = (sts.cmd == CMD_SAMPLE) && (sts.key_count == '0);
            end
         end
         ST_FIRST_RD: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = '0;
         end
         ST_FIRST_CHK: ctl.res_key = (sts.key_count == CNT_W'(1)) || sts.le_first;
         ST_SEG_RD:    ctl.rd_en = 1'b1;
         ST_SEG_CHK: begin
            ctl.seg_load  = 1'b1;
            ctl.res_key   = sts.brackets && sts.span_zero;
            ctl.div_start = sts.brackets && !sts.span_zero;
         end
         ST_DIV:  ctl.div_step = 1'b1;
         ST_MUL:  ctl.mul = 1'b1;
         ST_SUM:  ctl.sum = 1'b1;
         ST_LAST_RD: begin
            ctl.rd_en  = 1'b1;
            ctl.rd_idx = IDX_W'(sts.key_count - CNT_W'(1));
         end
         ST_LAST_CHK: ctl.res_key = 1'b1;
         ST_OUT:      ctl = ctl;
         default:     ctl = ctl;
      endcase
   end

   // Only sample commands leave idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && pend_ff && sts.cmd != CMD_SAMPLE) |=> state_ff == ST_IDLE)
      else $error("non-sample command started a search");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && !rsp_ready) |=> state_ff == ST_OUT)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !rsp_valid)
      else $error("request taken while a result is pending");

endmodule

FILE: sv/kvs_datapath.sv
// ============================================================================
// kvs_datapath: key table, divider and interpolator
// Key memory, restoring divider for the fraction, three multiply lanes.
// ============================================================================
module kvs_datapath
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  req_type req_data,
   input  ctl_type ctl,
   output sts_type sts,
   output rsp_type rsp_data
);

   logic [127:0] mem_a [MAX_KEYS];   // {time, x, y, z}
   logic [127:0] mem_b [MAX_KEYS];   // copy for reading the following entry
   logic [127:0] rda_ff, rdb_ff;

   req_type          req_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] nxt_idx;

   always_ff @(posedge clock) begin
      if (ctl.load_req) req_ff <= req_data;
   end

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) count_in = '0;
      else if (ctl.append && count_ff < CNT_W'(MAX_KEYS)) count_in = count_ff + CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

   assign nxt_idx = ctl.rd_idx + IDX_W'(1);

   always_ff @(posedge clock) begin
      if (ctl.append && count_ff < CNT_W'(MAX_KEYS)) begin
         mem_a[count_ff[IDX_W-1:0]] <= {req_ff.item_time, req_ff.in_x, req_ff.in_y, req_ff.in_z};
         mem_b[count_ff[IDX_W-1:0]] <= {req_ff.item_time, req_ff.in_x, req_ff.in_y, req_ff.in_z};
      end
      if (ctl.rd_en) begin
         rda_ff <= mem_a[ctl.rd_idx];
         rdb_ff <= mem_b[nxt_idx];
      end
   end

   logic [31:0] t0, t1, tq;
   assign t0 = rda_ff[127:96];
   assign t1 = rdb_ff[127:96];
   assign tq = req_ff.item_time;

   assign sts.key_count = count_ff;
   assign sts.cmd       = req_ff.cmd;
   assign sts.le_first  = (tq <= t0);
   assign sts.brackets  = (t0 <= tq) && (tq <= t1);
   assign sts.span_zero = (t0 == t1);

   // Segment latch and restoring divider: quotient of (dt << 16) / span.
   logic [95:0] v0_ff, v1_ff;
   logic [31:0] span_ff;
   logic [47:0] dvd_ff, dvd_in;
   logic [32:0] rem_ff, rem_in;
   logic [48:0] quo_ff, quo_in;
   logic [32:0] trial;

   assign trial = {rem_ff[31:0], dvd_ff[47]} - {1'b0, span_ff};

   always_comb begin
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      if (ctl.div_start) begin
         dvd_in = {tq - t0, 16'h0};
         rem_in = '0;
         quo_in = '0;
      end else if (ctl.div_step) begin
         dvd_in = {dvd_ff[46:0], 1'b0};
         if (!trial[32]) begin
            rem_in = trial;
            quo_in = {quo_ff[47:0], 1'b1};
         end else begin
            rem_in = {rem_ff[31:0], dvd_ff[47]};
            quo_in = {quo_ff[47:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (ctl.seg_load) begin
         v0_ff   <= rda_ff[95:0];
         v1_ff   <= rdb_ff[95:0];
         span_ff <= t1 - t0;
      end
   end

   // Interpolation lanes: (v1 - v0) * f, then floor shift and add.
   logic signed [32:0] diff [3];
   logic signed [50:0] prod_ff [3];
   logic signed [FRAC_W:0] frac_s;
   assign frac_s = $signed({1'b0, quo_ff[FRAC_W-1:0]});

   rsp_type rsp_ff;
   logic signed [31:0] lerp [3];

   for (genvar c = 0; c < 3; c++) begin : g_lane
      assign diff[c] = $signed({v1_ff[95-32*c], v1_ff[95-32*c -: 32]})
                     - $signed({v0_ff[95-32*c], v0_ff[95-32*c -: 32]});
      always_ff @(posedge clock) begin
         if (ctl.mul) prod_ff[c] <= 51'(diff[c] * frac_s);
      end
      assign lerp[c] = 32'($signed(v0_ff[95-32*c -: 32]) + prod_ff[c][47:16]);
   end

   always_ff @(posedge clock) begin
      if (ctl.res_one)      rsp_ff <= {ONE_Q16, ONE_Q16, ONE_Q16};
      else if (ctl.res_key) rsp_ff <= rda_ff[95:0];
      else if (ctl.sum)     rsp_ff <= {lerp[0], lerp[1], lerp[2]};
   end

   assign rsp_data = rsp_ff;

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(MAX_KEYS))
      else $error("key count overflow");
   assert property (@(posedge clock) disable iff (reset)
      ctl.div_step |-> span_ff != '0)
      else $error("divide by zero span");
   assert property (@(posedge clock) disable iff (reset)
      ctl.mul |-> quo_ff <= 49'h10000)
      else $error("fraction above one");

endmodule

FILE: sv/keyframe_vector_sampler_core.sv
// ============================================================================
// keyframe_vector_sampler_core: keyframe table with linear sampling
// Clear, append and sample commands on one request channel.
// ============================================================================
// Clear and append give no result beat; one beat at a time.
// A sample on an empty table answers (1,1,1); otherwise the first key is read
// and returned if it answers, else the table is scanned segment by segment.
// A zero-length bracketing segment returns its first key without dividing;
// interpolation runs the bit-serial divider, then the multiply and add steps.
// Synchronous active-high reset empties the table; stored keys are not cleared.
module keyframe_vector_sampler_core
   import kvs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   ctl_type ctl;
   sts_type sts;

   // The controller sequences every beat; the datapath holds the table.
   kvs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .ctl       (ctl)
   );

   kvs_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .sts      (sts),
      .rsp_data (rsp_data)
   );

endmodule

FILE: bench/tb_top.sv
// ============================================================================
// tb_top: self-checking bench for the keyframe vector sampler core
// Drives clear, append and sample beats with random idling on both channels
// and checks each sampled vector against a behavioral interpolation model.
// ============================================================================
module tb_top;
   import kvs_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   keyframe_vector_sampler_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Shadow copy of the keyframe table, updated as request beats are accepted.
   int unsigned    shadow_count;
   logic [31:0]    shadow_time [MAX_KEYS];
   logic [31:0]    shadow_val  [MAX_KEYS][3];
   rsp_type        pending_vectors[$];
   int             fail_count;
   int             samples_seen;
   int             appends_sent;
   int             rsp_wait;

   function automatic logic [31:0] lerp_component(logic [31:0] a, logic [31:0] b,
                                                  longint frac);
      longint sa, sb, p, q;
      sa = longint'(signed'(a));
      sb = longint'(signed'(b));
      p  = (sb - sa) * frac;
      // Floor division by 2^16 toward minus infinity.
      if (p >= 0) q = p / 65536;
      else q = -((-p + 65535) / 65536);
      return 32'(sa + q);
   endfunction

   function automatic rsp_type sample_vector(logic [31:0] t);
      rsp_type r;
      logic [63:0] span, frac;
      int unsigned k;
      if (shadow_count == 0) begin
         r.out_x = ONE_Q16; r.out_y = ONE_Q16; r.out_z = ONE_Q16;
         return r;
      end
      if (shadow_count == 1 || t <= shadow_time[0]) begin
         r.out_x = shadow_val[0][0]; r.out_y = shadow_val[0][1];
         r.out_z = shadow_val[0][2];
         return r;
      end
      for (k = 0; k + 1 < shadow_count; k++) begin
         if (shadow_time[k] <= t && t <= shadow_time[k+1]) begin
            span = 64'(shadow_time[k+1] - shadow_time[k]);
            if (span == 0) begin
               r.out_x = shadow_val[k][0]; r.out_y = shadow_val[k][1];
               r.out_z = shadow_val[k][2];
               return r;
            end
            frac = (64'(t - shadow_time[k]) << 16) / span;
            r.out_x = lerp_component(shadow_val[k][0], shadow_val[k+1][0], frac);
            r.out_y = lerp_component(shadow_val[k][1], shadow_val[k+1][1], frac);
            r.out_z = lerp_component(shadow_val[k][2], shadow_val[k+1][2], frac);
            return r;
         end
      end
      k = shadow_count - 1;
      r.out_x = shadow_val[k][0]; r.out_y = shadow_val[k][1];
      r.out_z = shadow_val[k][2];
      return r;
   endfunction

   // Apply one accepted request beat to the shadow table.
   task automatic absorb_request(req_type q);
      case (cmd_type'(q.cmd))
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         CMD_APPEND: begin
            if (shadow_count < MAX_KEYS) begin
               shadow_time[shadow_count]   = q.item_time;
               shadow_val[shadow_count][0] = q.in_x;
               shadow_val[shadow_count][1] = q.in_y;
               shadow_val[shadow_count][2] = q.in_z;
               shadow_count++;
            end
         end
         CMD_SAMPLE: begin
            pending_vectors.insert(pending_vectors.size(), sample_vector(q.item_time));
         end
         default: ;
      endcase
   endtask

   // Send one beat: random idle gap first, then hold valid until accepted.
   // Valid only drops when a gap follows, so back-to-back beats keep it high.
   task automatic send_beat(req_type q);
      int gap;
      gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      absorb_request(q);
   endtask

   function automatic req_type make_req(cmd_type c, logic [31:0] t,
                                        logic [31:0] x, logic [31:0] y,
                                        logic [31:0] z);
      req_type q;
      q.cmd = c; q.item_time = t; q.in_x = x; q.in_y = y; q.in_z = z;
      return q;
   endfunction

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'($urandom_range(0, 131072)) - 32'd65536;
         default: return $urandom;
      endcase
   endfunction

   // Directed rows. A typed-in expectation is checked in addition to the
   // model prediction; rows without one rely on the model alone.
   typedef struct {
      req_type q;
      bit      has_fixed;
      rsp_type fixed;
   } dir_row_type;

   dir_row_type dir_rows[$];
   rsp_type     fixed_vectors[$];
   bit          fixed_flags[$];

   task automatic add_row(req_type q, bit has_fixed, logic [31:0] fx,
                          logic [31:0] fy, logic [31:0] fz);
      dir_row_type r;
      r.q = q; r.has_fixed = has_fixed;
      r.fixed.out_x = fx; r.fixed.out_y = fy; r.fixed.out_z = fz;
      dir_rows.insert(dir_rows.size(), r);
   endtask

   // Response side: ready rises after a random wait, then each result beat
   // is compared field by field.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  = $urandom_range(0, 12);
      end else if (rsp_valid && rsp_ready) begin
         samples_seen++;
         if (pending_vectors.size() == 0) begin
            $error("unexpected response beat %h", rsp_data);
            fail_count++;
         end else begin
            want = pending_vectors.pop_front();
            if (rsp_data.out_x !== want.out_x) begin
               $error("out_x expected %h actual %h", want.out_x, rsp_data.out_x);
               fail_count++;
            end
            if (rsp_data.out_y !== want.out_y) begin
               $error("out_y expected %h actual %h", want.out_y, rsp_data.out_y);
               fail_count++;
            end
            if (rsp_data.out_z !== want.out_z) begin
               $error("out_z expected %h actual %h", want.out_z, rsp_data.out_z);
               fail_count++;
            end
            if (fixed_flags.size() > 0) begin
               if (fixed_flags.pop_front() && rsp_data !== fixed_vectors[0]) begin
                  $error("directed vector expected %h actual %h",
                         fixed_vectors[0], rsp_data);
                  fail_count++;
               end
               void'(fixed_vectors.pop_front());
            end
         end
         rsp_wait = $urandom_range(0, 12);
         rsp_ready <= (rsp_wait == 0);
      end else if (rsp_valid && !rsp_ready) begin
         if (rsp_wait > 0) rsp_wait--;
         if (rsp_wait == 0) rsp_ready <= 1'b1;
      end
   end

   initial begin
      #20_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      req_type q;
      logic [31:0] t, base;
      int n, mode, k;
      fail_count   = 0;
      samples_seen = 0;
      appends_sent = 0;
      shadow_count = 0;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty table, single key, extremes, zero-length
      // segment, out-of-order key, unused command, clear.
      add_row(make_req(CMD_SAMPLE, 32'h0, 0, 0, 0), 1'b1, ONE_Q16, ONE_Q16, ONE_Q16);
      add_row(make_req(CMD_SAMPLE, 32'hffff_ffff, 0, 0, 0), 1'b1,
              ONE_Q16, ONE_Q16, ONE_Q16);
      add_row(make_req(CMD_APPEND, 32'h0001_0000, 32'h8000_0000, 32'h7fff_ffff,
                       32'h0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'hffff_ffff, 0, 0, 0), 1'b1,
              32'h8000_0000, 32'h7fff_ffff, 32'h0);
      add_row(make_req(CMD_APPEND, 32'h0003_0000, 32'h7fff_ffff, 32'h8000_0000,
                       32'hffff_ffff), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'h0, 0, 0, 0), 1'b1,
              32'h8000_0000, 32'h7fff_ffff, 32'h0);
      add_row(make_req(CMD_SAMPLE, 32'h0002_0000, 0, 0, 0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'h0003_0000, 0, 0, 0), 1'b1,
              32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
      add_row(make_req(CMD_APPEND, 32'h0003_0000, 32'h1, 32'h2, 32'h3), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'h0003_0000, 0, 0, 0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_APPEND, 32'h0002_0000, 32'h5, 32'h6, 32'h7), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_APPEND, 32'hffff_ffff, 32'h0, 32'h0, 32'h0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'hffff_fffe, 0, 0, 0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'h0002_8000, 0, 0, 0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_NONE, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
                       32'hffff_ffff), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_CLEAR, 32'hffff_ffff, 0, 0, 0), 1'b0, 0, 0, 0);
      add_row(make_req(CMD_SAMPLE, 32'h1234_5678, 0, 0, 0), 1'b1,
              ONE_Q16, ONE_Q16, ONE_Q16);

      foreach (dir_rows[i]) begin
         if (dir_rows[i].q.cmd == CMD_SAMPLE) begin
            fixed_flags.insert(fixed_flags.size(), dir_rows[i].has_fixed);
            fixed_vectors.insert(fixed_vectors.size(), dir_rows[i].fixed);
         end
         send_beat(dir_rows[i].q);
      end

      // Random part: mostly fill-then-sample phases over ascending keys,
      // some overfilling the table, with noise commands mixed in.
      n = 0;
      while (n < 900) begin
         send_beat(make_req(CMD_CLEAR, $urandom, $urandom, $urandom, $urandom));
         n++;
         mode = $urandom_range(0, 9);
         k = (mode == 0) ? $urandom_range(MAX_KEYS, MAX_KEYS + 3)
                         : $urandom_range(0, 8);
         base = (mode == 1) ? 32'hfff0_0000 : 32'($urandom_range(0, 32'h0010_0000));
         t = base;
         for (int j = 0; j < k; j++) begin
            if (mode == 2) t = $urandom;                 // unordered keys
            else if ($urandom_range(0, 5) != 0)
               t = t + 32'($urandom_range(0, (mode == 1) ? 32'h1000 : 32'h4_0000));
            send_beat(make_req(CMD_APPEND, t, rand_value(), rand_value(),
                               rand_value()));
            n++;
         end
         repeat ($urandom_range(2, 10)) begin
            case ($urandom_range(0, 9))
               0: q = make_req(CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom);
               1: q = make_req(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
               2: q = make_req(CMD_SAMPLE, (k > 0) ? t + 32'($urandom_range(0, 3))
                                                   : 32'hffff_ffff, 0, 0, 0);
               3: q = make_req(CMD_SAMPLE, base - 32'($urandom_range(0, 2)), 0, 0, 0);
               default: q = make_req(CMD_SAMPLE,
                                     base + 32'($urandom_range(0, t - base)),
                                     $urandom, $urandom, $urandom);
            endcase
            if (q.cmd == CMD_SAMPLE) begin
               fixed_flags.insert(fixed_flags.size(), 1'b0);
               fixed_vectors.insert(fixed_vectors.size(), '0);
            end
            send_beat(q);
            n++;
         end
      end

      req_valid <= 1'b0;
      while (pending_vectors.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("Sent %0d random beats after the directed table.", n);
      $display("Checked %0d sampled vectors against the interpolation model.",
               samples_seen);
      if (fail_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

FILE: filelist.f
sv/kvs_pkg.sv
sv/kvs_ctrl.sv
sv/kvs_datapath.sv
sv/keyframe_vector_sampler_core.sv
bench/tb_top.sv
